FILE: rtl/core/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// shared types and constants of the trace frame deformatter
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int BYTE_W       = 8;
  localparam int ID_W         = 7;
  localparam int STORE_DEPTH  = 15;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int POS_W        = 4;
  localparam int SLOT_W       = ADDR_W - 1;

  localparam logic [POS_W-1:0]  AUX_POS        = 4'd15;
  localparam logic [ADDR_W-1:0] LAST_STORE_IDX = 4'd14;
  localparam logic [SLOT_W-1:0] LAST_SLOT      = 3'd7;
  localparam logic [ID_W-1:0]   ACTIVE_RESET   = 7'd4;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_DECODE  = 3'b010,
    ST_FLUSH   = 3'b100
  } state_t;

  typedef struct packed {
    logic store;        // write the accepted byte into the frame store
    logic capture_aux;  // take the accepted byte as the aux byte
    logic step;         // decode the stored byte now on the read port
    logic flush;        // push the held result out as last of frame
  } ctrl_cmd_t;

  typedef struct packed {
    logic pos_is_aux;   // next byte is the aux byte
    logic idx_last;     // decoding the final stored byte
    logic blocked;      // a new result cannot be taken this cycle
    logic pend_valid;   // a result is held back
    logic out_free;     // output register can load
  } ctrl_status_t;

endpackage

FILE: rtl/core/tdf_ram.sv
// ----------------------------------------------------------------------------
// tdf_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module tdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/tdf_datapath.sv
// ----------------------------------------------------------------------------
// tdf_datapath
// frame store, slot decode, held result and output register
// ----------------------------------------------------------------------------
module tdf_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  tdf_pkg::ctrl_cmd_t             cmd,
  output tdf_pkg::ctrl_status_t          status,
  input  logic [tdf_pkg::BYTE_W-1:0]     frame_byte,
  input  logic                           cfg_we,
  input  logic [tdf_pkg::ID_W-1:0]       cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tdf_pkg::ID_W-1:0]       source_id,
  output logic [tdf_pkg::BYTE_W-1:0]     data_byte,
  output logic                           id_out_of_range,
  output logic                           aux_fault,
  output logic                           last_of_frame
);

  logic [tdf_pkg::POS_W-1:0]  byte_position;
  logic [tdf_pkg::ADDR_W-1:0] rd_index;
  logic [tdf_pkg::ADDR_W-1:0] rd_addr;
  logic [tdf_pkg::BYTE_W-1:0] rd_data;
  logic [tdf_pkg::BYTE_W-1:0] aux_byte;
  logic [tdf_pkg::ID_W-1:0]   current_source;
  logic [tdf_pkg::ID_W-1:0]   odd_source;
  logic [tdf_pkg::ID_W-1:0]   active_sources;

  logic                       pend_valid;
  logic [tdf_pkg::ID_W-1:0]   pend_src;
  logic [tdf_pkg::BYTE_W-1:0] pend_data;
  logic                       pend_oor;
  logic                       pend_fault;

  logic [tdf_pkg::SLOT_W-1:0] slot;
  logic                       is_even;
  logic                       abit;
  logic                       is_id;
  logic [tdf_pkg::ID_W-1:0]   nid;
  logic                       gen;
  logic                       gen_fault;
  logic                       gen_oor;
  logic [tdf_pkg::ID_W-1:0]   gen_src;
  logic [tdf_pkg::BYTE_W-1:0] gen_data;
  logic                       out_free;
  logic                       blocked;
  logic                       advance;
  logic                       step_move;
  logic                       flush_move;
  logic                       idx_last;

  tdf_ram #(
    .WIDTH (tdf_pkg::BYTE_W),
    .DEPTH (tdf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (byte_position),
    .wdata (frame_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign is_even = ~rd_index[0];
  assign slot    = rd_index[tdf_pkg::ADDR_W-1:1];
  assign abit    = aux_byte[slot];
  assign is_id   = rd_data[0];
  assign nid     = rd_data[tdf_pkg::BYTE_W-1:1];

  always_comb begin
    gen       = 1'b0;
    gen_fault = 1'b0;
    gen_src   = current_source;
    gen_data  = rd_data;
    if (is_even) begin
      gen_fault = is_id & abit & (slot == tdf_pkg::LAST_SLOT);
      gen       = gen_fault | (~is_id & (current_source != '0));
      gen_data  = gen_fault ? '0 : {rd_data[tdf_pkg::BYTE_W-1:1], abit};
    end else begin
      gen     = (odd_source != '0);
      gen_src = odd_source;
    end
  end

  assign gen_oor    = ~gen_fault & (gen_src > active_sources);
  assign out_free   = ~out_valid | out_ready;
  assign blocked    = gen & pend_valid & ~out_free;
  assign advance    = cmd.step & ~blocked;
  assign step_move  = advance & gen & pend_valid;
  assign flush_move = cmd.flush & pend_valid & out_free;
  assign idx_last   = (rd_index == tdf_pkg::LAST_STORE_IDX);

  // hold the address while stalled so the read data stays put
  always_comb begin
    rd_addr = '0;
    if (cmd.step) begin
      rd_addr = (advance && !idx_last) ? rd_index + 1'b1 : rd_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      rd_index       <= '0;
      current_source <= '0;
      odd_source     <= '0;
      active_sources <= tdf_pkg::ACTIVE_RESET;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_sources <= cfg_data;
      end
      if (cmd.store) begin
        byte_position <= byte_position + 1'b1;
      end
      if (cmd.capture_aux) begin
        byte_position <= '0;
        rd_index      <= '0;
      end
      if (advance) begin
        rd_index <= rd_index + 1'b1;
        if (is_even) begin
          if (is_id && !gen_fault) begin
            current_source <= nid;
          end
          if (is_id) begin
            odd_source <= abit ? current_source : nid;
          end else begin
            odd_source <= current_source;
          end
        end
      end
      if (advance && gen) begin
        pend_valid <= 1'b1;
      end else if (flush_move) begin
        pend_valid <= 1'b0;
      end
      if (step_move || flush_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_aux) begin
      aux_byte <= frame_byte;
    end
    if (advance && gen) begin
      pend_src   <= gen_src;
      pend_data  <= gen_data;
      pend_oor   <= gen_oor;
      pend_fault <= gen_fault;
    end
    if (step_move || flush_move) begin
      source_id       <= pend_src;
      data_byte       <= pend_data;
      id_out_of_range <= pend_oor;
      aux_fault       <= pend_fault;
      last_of_frame   <= flush_move;
    end
  end

  assign status.pos_is_aux = (byte_position == tdf_pkg::AUX_POS);
  assign status.idx_last   = idx_last;
  assign status.blocked    = blocked;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

endmodule

FILE: rtl/core/tdf_ctrl.sv
// ----------------------------------------------------------------------------
// tdf_ctrl
// sequencer: collect a frame, walk the stored bytes, flush the last result
// ----------------------------------------------------------------------------
module tdf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tdf_pkg::ctrl_status_t status,
  output tdf_pkg::ctrl_cmd_t    cmd
);

  tdf_pkg::state_t state;
  tdf_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tdf_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.pos_is_aux) begin
            cmd.capture_aux = 1'b1;
            state_next      = tdf_pkg::ST_DECODE;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      tdf_pkg::ST_DECODE: begin
        cmd.step = 1'b1;
        if (!status.blocked && status.idx_last) begin
          state_next = tdf_pkg::ST_FLUSH;
        end
      end
      tdf_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (!status.pend_valid || status.out_free) begin
          state_next = tdf_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_next = tdf_pkg::ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdf_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/trace_frame_deformatter.sv
// ----------------------------------------------------------------------------
// trace_frame_deformatter
// splits 16-byte trace frames into data bytes tagged with their source id
// ----------------------------------------------------------------------------
// bytes 0..14 of a frame are taken one per cycle; the aux byte starts decode
// decode walks the frame store one byte per cycle through its single read
// port, holding while the output is stalled, then a flush step follows
// no input is taken during decode; a decoded result waits in the held result
// register until the next result or the flush moves it to the output register
// sync reset: position and source id to 0, active_sources to 4, store kept
// ----------------------------------------------------------------------------
module trace_frame_deformatter (
  input  logic                       clk,
  input  logic                       rst,
  // raw byte stream
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tdf_pkg::BYTE_W-1:0] frame_byte,
  // decoded results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tdf_pkg::ID_W-1:0]   source_id,
  output logic [tdf_pkg::BYTE_W-1:0] data_byte,
  output logic                       id_out_of_range,
  output logic                       aux_fault,
  output logic                       last_of_frame,
  // active_sources register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tdf_pkg::ID_W-1:0]   cfg_data
);

  tdf_pkg::ctrl_cmd_t    cmd;
  tdf_pkg::ctrl_status_t status;

  // the register takes a write transfer in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: owns the input handshake and the frame phases
  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: frame store, source tracking, one held result so that the
  // final result of a frame can be marked, then the output register
  tdf_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .frame_byte      (frame_byte),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .source_id       (source_id),
    .data_byte       (data_byte),
    .id_out_of_range (id_out_of_range),
    .aux_fault       (aux_fault),
    .last_of_frame   (last_of_frame)
  );

endmodule

FILE: rtl/core/tdf_checker.sv
// ----------------------------------------------------------------------------
// tdf_checker
// port-level checks of the trace frame deformatter, bound to the top level
// ----------------------------------------------------------------------------
module tdf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [tdf_pkg::BYTE_W-1:0] frame_byte,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tdf_pkg::ID_W-1:0]   source_id,
  input logic [tdf_pkg::BYTE_W-1:0] data_byte,
  input logic                       id_out_of_range,
  input logic                       aux_fault,
  input logic                       last_of_frame,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [tdf_pkg::ID_W-1:0]   cfg_data
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(source_id) && $stable(data_byte)
      && $stable(last_of_frame) && $stable(aux_fault))
    else $error("result changed while stalled");

  // a fault result closes its frame with no data and no range flag
  a_fault_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && aux_fault |-> last_of_frame && (data_byte == '0) && !id_out_of_range)
    else $error("malformed fault result");

  // data for source zero is discarded, only a fault can carry it
  a_no_zero_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && (source_id == '0) |-> aux_fault)
    else $error("result for discarded source");

  // nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind trace_frame_deformatter tdf_checker u_tdf_checker (.*);

FILE: tb/sv/trace_frame_deformatter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trace_frame_deformatter_checker
// watches the byte, result and register channels of the deformatter, keeps
// its own copy of the frame decode and compares every result transfer
// ----------------------------------------------------------------------------
module trace_frame_deformatter_checker
  import tdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] frame_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [ID_W-1:0]   source_id,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              id_out_of_range,
  input  logic              aux_fault,
  input  logic              last_of_frame,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_data,
  output int                fail_count,
  output int                outstanding
);

  localparam int SLOT_COUNT = 8;
  localparam int MAX_SHOWN  = 40;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] dat;
    logic              oor;
    logic              fault;
    logic              last;
  } trace_result_t;

  logic [BYTE_W-1:0] held_bytes [STORE_DEPTH];
  logic [POS_W-1:0]  fill_pos;
  logic [ID_W-1:0]   cur_source;
  logic [ID_W-1:0]   source_limit;
  trace_result_t     awaited_q [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_SHOWN) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic trace_result_t make_result(input logic [ID_W-1:0] id,
                                                input logic [BYTE_W-1:0] dat,
                                                input logic fault);
    trace_result_t r;
    r.id    = id;
    r.dat   = dat;
    r.fault = fault;
    r.oor   = !fault && (id > source_limit);
    r.last  = 1'b0;
    return r;
  endfunction

  // walks the eight slots of a complete frame, aux byte in hand
  task automatic decode_frame(input logic [BYTE_W-1:0] aux);
    trace_result_t     frame_q [$];
    trace_result_t     tail;
    logic [BYTE_W-1:0] ev;
    logic [BYTE_W-1:0] odd;
    logic              abit;
    bit                stop;
    int                n;
    stop = 1'b0;
    for (int s = 0; s < SLOT_COUNT && !stop; s++) begin
      ev   = held_bytes[2*s];
      odd  = (s < SLOT_COUNT-1) ? held_bytes[2*s+1] : '0;
      abit = aux[s];
      if (ev[0]) begin
        if (abit && s == SLOT_COUNT-1) begin
          // fault ends the frame, source kept
          frame_q.push_back(make_result(cur_source, '0, 1'b1));
          stop = 1'b1;
        end else if (abit) begin
          // odd byte still belongs to the old source
          if (cur_source != '0) frame_q.push_back(make_result(cur_source, odd, 1'b0));
          cur_source = ev[BYTE_W-1:1];
        end else begin
          cur_source = ev[BYTE_W-1:1];
          if (cur_source != '0 && s != SLOT_COUNT-1) begin
            frame_q.push_back(make_result(cur_source, odd, 1'b0));
          end
        end
      end else if (cur_source != '0) begin
        frame_q.push_back(make_result(cur_source, {ev[BYTE_W-1:1], abit}, 1'b0));
        if (s != SLOT_COUNT-1) frame_q.push_back(make_result(cur_source, odd, 1'b0));
      end
    end
    n = frame_q.size();
    if (n != 0) begin
      tail = frame_q[n-1];
      tail.last = 1'b1;
      frame_q[n-1] = tail;
    end
    foreach (frame_q[k]) awaited_q.push_back(frame_q[k]);
  endtask

  task automatic check_result();
    trace_result_t want;
    if (awaited_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: id %0d data %02h fault %0b",
                                source_id, data_byte, aux_fault));
      return;
    end
    want = awaited_q.pop_front();
    if (source_id !== want.id)
      report_mismatch($sformatf("source_id %0d, expected %0d", source_id, want.id));
    if (data_byte !== want.dat)
      report_mismatch($sformatf("data_byte %02h, expected %02h", data_byte, want.dat));
    if (id_out_of_range !== want.oor)
      report_mismatch($sformatf("id_out_of_range %0b, expected %0b", id_out_of_range,
                                want.oor));
    if (aux_fault !== want.fault)
      report_mismatch($sformatf("aux_fault %0b, expected %0b", aux_fault, want.fault));
    if (last_of_frame !== want.last)
      report_mismatch($sformatf("last_of_frame %0b, expected %0b", last_of_frame,
                                want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_pos     = '0;
      cur_source   = '0;
      source_limit = ACTIVE_RESET;
      awaited_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) source_limit = cfg_data;
      if (in_valid && in_ready) begin
        if (fill_pos == AUX_POS) begin
          fill_pos = '0;
          decode_frame(frame_byte);
        end else begin
          held_bytes[fill_pos] = frame_byte;
          fill_pos = fill_pos + 1'b1;
        end
      end
      outstanding <= awaited_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_trace_frame_deformatter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trace_frame_deformatter
// drives 16-byte trace frames into the deformatter: a handful of hand-built
// frames for the corner cases, then random frames over four handshake
// phases with a new source count for each; the checker does the scoring
// ----------------------------------------------------------------------------
module tb_trace_frame_deformatter;
  import tdf_pkg::*;

  localparam int FRAME_LEN        = 16;
  localparam int FRAMES_PER_PHASE = 4;
  localparam int SETTLE_CYCLES    = 40;    // decode of an empty frame plus margin
  localparam int HOLD_OFF_CYCLES  = 300;   // long receiver back-pressure
  localparam int WATCHDOG_LIMIT   = 3000;  // cycles with no transfer at all

  typedef logic [BYTE_W-1:0] frame_t [FRAME_LEN];

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic [BYTE_W-1:0] frame_byte = '0;
  logic              out_ready  = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic [ID_W-1:0]   cfg_data   = '0;

  logic              in_ready;
  logic              out_valid;
  logic [ID_W-1:0]   source_id;
  logic [BYTE_W-1:0] data_byte;
  logic              id_out_of_range;
  logic              aux_fault;
  logic              last_of_frame;
  logic              cfg_ready;

  int                fail_count;
  int                outstanding;

  // handshake shaping, percentages out of a hundred
  int                tx_idle_pct   = 0;
  int                rx_stall_pct  = 0;
  int                hold_requests = 0;
  int                hold_served   = 0;
  int                hold_left     = 0;
  int                quiet_cycles  = 0;
  logic [ID_W-1:0]   limit_now     = ACTIVE_RESET;

  always #5 clk = ~clk;

  trace_frame_deformatter i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .frame_byte      (frame_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .source_id       (source_id),
    .data_byte       (data_byte),
    .id_out_of_range (id_out_of_range),
    .aux_fault       (aux_fault),
    .last_of_frame   (last_of_frame),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  trace_frame_deformatter_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .frame_byte      (frame_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .source_id       (source_id),
    .data_byte       (data_byte),
    .id_out_of_range (id_out_of_range),
    .aux_fault       (aux_fault),
    .last_of_frame   (last_of_frame),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_OFF_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL trace_frame_deformatter");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one byte transfer; valid stays up across back-to-back bytes
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_part(input frame_t f, input int lo, input int hi);
    for (int i = lo; i <= hi; i++) push_byte(f[i]);
  endtask

  // register write only once the block has drained; empty frames give no
  // result to wait for, hence the settle time on top
  task automatic write_limit(input logic [ID_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_now  = v;
  endtask

  // random frame: mostly slot-structured with ids clustered around the
  // active count so that both in-range and flagged sources turn up often,
  // now and then a frame of pure noise
  task automatic build_frame(output frame_t f);
    int              top_id;
    int              kind;
    logic [ID_W-1:0] pick;
    top_id = (limit_now > 7'd124) ? 127 : int'(limit_now) + 2;
    if ($urandom_range(99) < 15) begin
      for (int i = 0; i < FRAME_LEN; i++) f[i] = BYTE_W'($urandom_range(255));
    end else begin
      for (int s = 0; s < 8; s++) begin
        kind = $urandom_range(99);
        if (kind < 12) begin
          f[2*s] = {7'd0, 1'b1};
        end else if (kind < 40) begin
          pick = ID_W'($urandom_range(top_id));
          f[2*s] = {pick, 1'b1};
        end else if (kind < 47) begin
          pick = ID_W'($urandom_range(127));
          f[2*s] = {pick, 1'b1};
        end else begin
          f[2*s] = {7'($urandom_range(127)), 1'b0};
        end
        if (s < 7) f[2*s+1] = BYTE_W'($urandom_range(255));
      end
      f[AUX_POS] = BYTE_W'($urandom_range(255));
    end
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct,
                           input logic [ID_W-1:0] lim, input bit squeeze);
    frame_t f;
    write_limit(lim);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    // long receiver hold-off while frames keep coming, to fill the block
    if (squeeze) hold_requests <= hold_requests + 1;
    repeat (FRAMES_PER_PHASE) begin
      build_frame(f);
      send_part(f, 0, FRAME_LEN-1);
    end
  endtask

  initial begin
    frame_t f;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // source 0 discards, aux bits keeping the odd byte with the old source,
    // low bit restored on data, flagged id, data in the last slot
    f = '{8'h01, 8'hFF, 8'hFE, 8'h00, 8'h07, 8'h3C, 8'h00, 8'hFF,
          8'h0B, 8'h80, 8'hFE, 8'h7F, 8'h09, 8'h55, 8'hAA, 8'h9C};
    send_part(f, 0, FRAME_LEN-1);

    // largest id, then a new id in the last slot with its aux bit clear
    f = '{8'hFF, 8'hA5, 8'h42, 8'h81, 8'h00, 8'hFF, 8'hFE, 8'h00,
          8'h03, 8'h5A, 8'h24, 8'hC3, 8'h10, 8'hEF, 8'h05, 8'h32};
    send_part(f, 0, FRAME_LEN-1);

    // every byte for source 0: a frame that gives no result
    f = '{8'h01, 8'hFF, 8'hFE, 8'hFF, 8'h01, 8'hFF, 8'hFE, 8'hFF,
          8'h01, 8'hFF, 8'hFE, 8'hFF, 8'h01, 8'hFF, 8'hFE, 8'hFE};
    send_part(f, 0, FRAME_LEN-1);

    // aux fault: id in the last slot with its aux bit set ends the frame
    f = '{8'h07, 8'h11, 8'h20, 8'h22, 8'h30, 8'h33, 8'h40, 8'h44,
          8'h50, 8'h55, 8'h60, 8'h66, 8'h70, 8'h77, 8'h13, 8'h82};
    send_part(f, 0, FRAME_LEN-1);

    // all data, fifteen results; source count changed half way through
    f = '{8'h3C, 8'hC3, 8'h00, 8'hFF, 8'hFE, 8'h01, 8'h80, 8'h7F,
          8'hAA, 8'h55, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h5A};
    send_part(f, 0, 7);
    write_limit(7'd2);
    send_part(f, 8, FRAME_LEN-1);

    // random frames, one handshake pattern per phase
    run_phase(0, 0, 7'd127, 1'b1);
    run_phase(57, 0, 7'd0, 1'b0);
    run_phase(0, 57, ID_W'($urandom_range(1, 10)), 1'b0);
    run_phase(25, 25, ID_W'($urandom_range(127)), 1'b0);

    // drain: every expected transfer in, then a little extra for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS trace_frame_deformatter");
    end else begin
      $display("FAIL trace_frame_deformatter");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tdf_pkg.sv
rtl/core/tdf_ram.sv
rtl/core/tdf_datapath.sv
rtl/core/tdf_ctrl.sv
rtl/core/trace_frame_deformatter.sv
rtl/core/tdf_checker.sv
tb/sv/trace_frame_deformatter_checker.sv
tb/sv/tb_trace_frame_deformatter.sv
